// ----- hw/rtl/ssd_pkg.sv -----
// Package for the stitch stream decoder: record modes, stitch kinds,
// special byte codes, the result struct and a sign extension helper.
// No dependencies.
package ssd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DELTA_W = 16;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned PHASE_W = 3;

	localparam logic [BYTE_W-1:0] LEAD_LONG_A   = 8'h7E;
	localparam logic [BYTE_W-1:0] LEAD_LONG_B   = 8'h7D;
	localparam logic [BYTE_W-1:0] LEAD_CMD      = 8'h7F;
	localparam logic [BYTE_W-1:0] CMD_TRIM      = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_STOP_MIN  = 8'h08;
	localparam logic [BYTE_W-1:0] CMD_SKIP_A    = 8'h17;
	localparam logic [BYTE_W-1:0] CMD_SKIP_B    = 8'h46;

	localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TRIM   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

	localparam logic [PHASE_W-1:0] PH_LEAD  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ONE   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_TWO   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_THREE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_FOUR  = 3'd4;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_LONG   = 3'b010,
		MODE_CMD    = 3'b100
	} ssd_mode_t;

	typedef struct packed {
		logic                valid;
		logic [DELTA_W-1:0]  dx;
		logic [DELTA_W-1:0]  dy;
		logic [KIND_W-1:0]   kind;
	} ssd_result_t;

	function automatic logic [DELTA_W-1:0] sext8(input logic [BYTE_W-1:0] v);
		return {{(DELTA_W-BYTE_W){v[BYTE_W-1]}}, v};
	endfunction

endpackage

// ----- hw/rtl/ssd_record.sv -----
// Record state machine of the stitch stream decoder: holds the record
// state and decodes one byte per step into at most one stitch.
// Depends on ssd_pkg.
module ssd_record (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [ssd_pkg::BYTE_W-1:0] data_byte,
	output ssd_pkg::ssd_result_t       result
);

	logic [ssd_pkg::PHASE_W-1:0] phase_q, phase_d;
	ssd_pkg::ssd_mode_t          mode_q, mode_d;
	logic [ssd_pkg::BYTE_W-1:0]  lead_q, lead_d;
	logic [ssd_pkg::BYTE_W-1:0]  low_q, low_d;
	logic [ssd_pkg::DELTA_W-1:0] hdx_q, hdx_d;
	logic                        pend_q, pend_d;

	always_comb begin
		logic emit;
		logic is_stop;
		emit    = 1'b0;
		is_stop = (data_byte >= ssd_pkg::CMD_STOP_MIN) && (data_byte != ssd_pkg::CMD_SKIP_A)
			&& (data_byte != ssd_pkg::CMD_SKIP_B);
		phase_d = phase_q;
		mode_d  = mode_q;
		lead_d  = lead_q;
		low_d   = low_q;
		hdx_d   = hdx_q;
		pend_d  = pend_q;
		result  = '{valid: 1'b0, dx: '0, dy: '0, kind: ssd_pkg::KIND_NORMAL};

		if (phase_q == ssd_pkg::PH_LEAD) begin
			lead_d  = data_byte;
			phase_d = ssd_pkg::PH_ONE;
			if (data_byte == ssd_pkg::LEAD_LONG_A || data_byte == ssd_pkg::LEAD_LONG_B) begin
				mode_d = ssd_pkg::MODE_LONG;
			end else if (data_byte == ssd_pkg::LEAD_CMD) begin
				mode_d = ssd_pkg::MODE_CMD;
			end else begin
				mode_d = ssd_pkg::MODE_NORMAL;
			end
		end else begin
			unique case (mode_q)
				ssd_pkg::MODE_NORMAL: begin
					if (phase_q == ssd_pkg::PH_ONE) begin
						emit        = 1'b1;
						result.dx   = ssd_pkg::sext8(lead_q);
						result.dy   = ssd_pkg::sext8(data_byte);
						result.kind = pend_q ? ssd_pkg::KIND_TRIM : ssd_pkg::KIND_NORMAL;
					end else begin
						phase_d = ssd_pkg::PH_LEAD;
						mode_d  = ssd_pkg::MODE_NORMAL;
					end
				end
				ssd_pkg::MODE_LONG: begin
					unique case (phase_q)
						ssd_pkg::PH_ONE: begin
							low_d   = data_byte;
							phase_d = ssd_pkg::PH_TWO;
						end
						ssd_pkg::PH_TWO: begin
							hdx_d   = {data_byte, low_q};
							phase_d = ssd_pkg::PH_THREE;
						end
						ssd_pkg::PH_THREE: begin
							low_d   = data_byte;
							phase_d = ssd_pkg::PH_FOUR;
						end
						ssd_pkg::PH_FOUR: begin
							emit        = 1'b1;
							result.dx   = hdx_q;
							result.dy   = {data_byte, low_q};
							result.kind = ssd_pkg::KIND_TRIM;
						end
						default: begin
							phase_d = ssd_pkg::PH_LEAD;
							mode_d  = ssd_pkg::MODE_NORMAL;
						end
					endcase
				end
				ssd_pkg::MODE_CMD: begin
					unique case (phase_q)
						ssd_pkg::PH_ONE: begin
							if (is_stop) begin
								emit        = 1'b1;
								result.kind = ssd_pkg::KIND_STOP;
							end else if (data_byte == ssd_pkg::CMD_TRIM) begin
								phase_d = ssd_pkg::PH_TWO;
							end else begin
								pend_d  = 1'b0;
								phase_d = ssd_pkg::PH_LEAD;
								mode_d  = ssd_pkg::MODE_NORMAL;
							end
						end
						ssd_pkg::PH_TWO: begin
							low_d   = data_byte;
							phase_d = ssd_pkg::PH_THREE;
						end
						ssd_pkg::PH_THREE: begin
							emit        = 1'b1;
							result.dx   = ssd_pkg::sext8(low_q);
							result.dy   = ssd_pkg::sext8(data_byte);
							result.kind = ssd_pkg::KIND_TRIM;
						end
						default: begin
							phase_d = ssd_pkg::PH_LEAD;
							mode_d  = ssd_pkg::MODE_NORMAL;
						end
					endcase
				end
				default: begin
					phase_d = ssd_pkg::PH_LEAD;
					mode_d  = ssd_pkg::MODE_NORMAL;
				end
			endcase
		end

		if (emit) begin
			phase_d = ssd_pkg::PH_LEAD;
			mode_d  = ssd_pkg::MODE_NORMAL;
			pend_d  = (result.kind == ssd_pkg::KIND_STOP);
		end
		result.valid = emit & step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssd_pkg::PH_LEAD;
			mode_q  <= ssd_pkg::MODE_NORMAL;
			lead_q  <= '0;
			low_q   <= '0;
			hdx_q   <= '0;
			pend_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			mode_q  <= mode_d;
			lead_q  <= lead_d;
			low_q   <= low_d;
			hdx_q   <= hdx_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// ----- hw/rtl/stitch_stream_decoder_top.sv -----
// Top level of the stitch stream decoder: input register, record decoder
// and result register between two streaming channels.
// Depends on ssd_pkg and ssd_record.
//
//   Channel   Direction  Content
//   s_axis    in         tdata[7:0] = data_byte
//   m_axis    out        tdata[15:0] = delta_x, tdata[31:16] = delta_y,
//                        tuser[1:0] = stitch_kind
//
// One byte is taken per cycle unless the result register is stalled.
// Each byte passes the input register; each stitch, the result register.
// Reset clears the record state, the pending trim mark and both valid flags.
// When the result register is stalled, one byte waits in the input register.
module stitch_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] delta_x, [31:16] delta_y
	output logic [1:0]  m_axis_tuser    // [1:0] stitch_kind
);

	logic                        valid_s1;
	logic [ssd_pkg::BYTE_W-1:0]  byte_s1;
	logic                        valid_s2;
	logic [ssd_pkg::DELTA_W-1:0] dx_s2;
	logic [ssd_pkg::DELTA_W-1:0] dy_s2;
	logic [ssd_pkg::KIND_W-1:0]  kind_s2;
	logic                        advance;
	ssd_pkg::ssd_result_t        res;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	ssd_record u_record (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			dx_s2   <= res.dx;
			dy_s2   <= res.dy;
			kind_s2 <= res.kind;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {dy_s2, dx_s2};
	assign m_axis_tuser  = kind_s2;

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && kind_s2 == ssd_pkg::KIND_STOP |-> dx_s2 == '0 && dy_s2 == '0)
		else $error("Colour stop item with nonzero deltas.");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s_axis_tready |-> valid_s2 && !m_axis_tready)
		else $error("Input held back without an output stall.");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> valid_s2)
		else $error("Decoded stitch not captured in the result register.");

endmodule

// ----- tb/stitch_stream_decoder_top_test.sv -----
// Self-checking testbench for stitch_stream_decoder_top: feeds directed and random
// stitch records as bytes and compares every stitch with an internal prediction.
// Depends on ssd_pkg and the decoder RTL.
module stitch_stream_decoder_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_BYTES = 1850;
	localparam int          STALL_NONE   = 0;
	localparam int          STALL_LIGHT  = 1;
	localparam int          STALL_HEAVY  = 2;

	typedef struct packed {
		logic [ssd_pkg::DELTA_W-1:0] dx;
		logic [ssd_pkg::DELTA_W-1:0] dy;
		logic [ssd_pkg::KIND_W-1:0]  kind;
	} stitch_t;

	class stitch_scoreboard;
		logic [ssd_pkg::PHASE_W-1:0] phase;
		ssd_pkg::ssd_mode_t          mode;
		logic [ssd_pkg::BYTE_W-1:0]  lead;
		logic [ssd_pkg::BYTE_W-1:0]  low_byte;
		logic [ssd_pkg::DELTA_W-1:0] jump_dx;
		logic                        trim_mark;
		stitch_t                     expected_q[$];
		int unsigned                 fail_count;

		function new();
			phase      = ssd_pkg::PH_LEAD;
			mode       = ssd_pkg::MODE_NORMAL;
			lead       = '0;
			low_byte   = '0;
			jump_dx    = '0;
			trim_mark  = 1'b0;
			fail_count = 0;
		endfunction

		function logic [ssd_pkg::DELTA_W-1:0] widen_byte(input logic [ssd_pkg::BYTE_W-1:0] b);
			return {{(ssd_pkg::DELTA_W-ssd_pkg::BYTE_W){b[ssd_pkg::BYTE_W-1]}}, b};
		endfunction

		function void push_stitch(input logic [ssd_pkg::DELTA_W-1:0] dx,
				input logic [ssd_pkg::DELTA_W-1:0] dy,
				input logic [ssd_pkg::KIND_W-1:0] kind);
			stitch_t s;
			s.dx   = dx;
			s.dy   = dy;
			s.kind = kind;
			expected_q.push_back(s);
			phase     = ssd_pkg::PH_LEAD;
			mode      = ssd_pkg::MODE_NORMAL;
			trim_mark = (kind == ssd_pkg::KIND_STOP);
		endfunction

		function void note_byte(input logic [ssd_pkg::BYTE_W-1:0] b);
			if (phase == ssd_pkg::PH_LEAD) begin
				lead = b;
				if (b == ssd_pkg::LEAD_LONG_A || b == ssd_pkg::LEAD_LONG_B)
					mode = ssd_pkg::MODE_LONG;
				else if (b == ssd_pkg::LEAD_CMD)
					mode = ssd_pkg::MODE_CMD;
				else
					mode = ssd_pkg::MODE_NORMAL;
				phase = ssd_pkg::PH_ONE;
			end else if (mode == ssd_pkg::MODE_NORMAL) begin
				push_stitch(widen_byte(lead), widen_byte(b),
					trim_mark ? ssd_pkg::KIND_TRIM : ssd_pkg::KIND_NORMAL);
			end else if (mode == ssd_pkg::MODE_LONG) begin
				case (phase)
					ssd_pkg::PH_ONE: begin
						low_byte = b;
						phase    = ssd_pkg::PH_TWO;
					end
					ssd_pkg::PH_TWO: begin
						jump_dx = {b, low_byte};
						phase   = ssd_pkg::PH_THREE;
					end
					ssd_pkg::PH_THREE: begin
						low_byte = b;
						phase    = ssd_pkg::PH_FOUR;
					end
					default: push_stitch(jump_dx, {b, low_byte}, ssd_pkg::KIND_TRIM);
				endcase
			end else begin
				case (phase)
					ssd_pkg::PH_ONE: begin
						if (b >= ssd_pkg::CMD_STOP_MIN && b != ssd_pkg::CMD_SKIP_A
								&& b != ssd_pkg::CMD_SKIP_B) begin
							push_stitch('0, '0, ssd_pkg::KIND_STOP);
						end else if (b == ssd_pkg::CMD_TRIM) begin
							phase = ssd_pkg::PH_TWO;
						end else begin
							trim_mark = 1'b0;
							phase     = ssd_pkg::PH_LEAD;
							mode      = ssd_pkg::MODE_NORMAL;
						end
					end
					ssd_pkg::PH_TWO: begin
						low_byte = b;
						phase    = ssd_pkg::PH_THREE;
					end
					default: push_stitch(widen_byte(low_byte), widen_byte(b),
						ssd_pkg::KIND_TRIM);
				endcase
			end
		endfunction

		function void check_stitch(input logic [ssd_pkg::DELTA_W-1:0] dx,
				input logic [ssd_pkg::DELTA_W-1:0] dy,
				input logic [ssd_pkg::KIND_W-1:0] kind);
			stitch_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected stitch: delta_x %0d, delta_y %0d, stitch_kind %0d",
					$signed(dx), $signed(dy), kind);
				fail_count++;
				return;
			end
			want = expected_q.pop_front();
			if (dx !== want.dx) begin
				$error("delta_x: expected %0d, got %0d", $signed(want.dx), $signed(dx));
				fail_count++;
			end
			if (dy !== want.dy) begin
				$error("delta_y: expected %0d, got %0d", $signed(want.dy), $signed(dy));
				fail_count++;
			end
			if (kind !== want.kind) begin
				$error("stitch_kind: expected %0d, got %0d", want.kind, kind);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	stitch_scoreboard sb;
	int unsigned      cycle_count = 0;
	int unsigned      bytes_sent = 0;
	int unsigned      burst_left = 0;
	bit               sender_gaps = 1'b1;
	int               stall_mode = STALL_LIGHT;
	logic [15:0]      ready_pattern = 16'hFFFF;
	int unsigned      pattern_age = 0;

	stitch_stream_decoder_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("stitch_stream_decoder_top_test NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_mode == STALL_NONE) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ready_pattern[0];
			if (pattern_age == 63) begin
				if (stall_mode == STALL_HEAVY)
					ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
				else
					ready_pattern <= 16'($urandom) | 16'h0001;
				pattern_age <= 0;
			end else begin
				ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
				pattern_age   <= pattern_age + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_stitch(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (sender_gaps && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left != 0)
			burst_left--;
		bytes_sent++;
	endtask

	task automatic wait_for_stitches();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		burst_left = 0;
	endtask

	task automatic send_record();
		int unsigned       sel;
		logic [7:0]        b;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			do b = 8'($urandom); while (b == ssd_pkg::LEAD_LONG_A
				|| b == ssd_pkg::LEAD_LONG_B || b == ssd_pkg::LEAD_CMD);
			send_byte(b);
			send_byte(8'($urandom));
		end else if (sel < 50) begin
			send_byte($urandom_range(0, 1) ? ssd_pkg::LEAD_LONG_A : ssd_pkg::LEAD_LONG_B);
			repeat (4) send_byte(8'($urandom));
		end else if (sel < 62) begin
			do b = 8'($urandom_range(ssd_pkg::CMD_STOP_MIN, 255));
			while (b == ssd_pkg::CMD_SKIP_A || b == ssd_pkg::CMD_SKIP_B);
			send_byte(ssd_pkg::LEAD_CMD);
			send_byte(b);
		end else if (sel < 76) begin
			send_byte(ssd_pkg::LEAD_CMD);
			send_byte(ssd_pkg::CMD_TRIM);
			send_byte(8'($urandom));
			send_byte(8'($urandom));
		end else if (sel < 88) begin
			sel = $urandom_range(0, 7);
			if (sel == 7)
				b = $urandom_range(0, 1) ? ssd_pkg::CMD_SKIP_A : ssd_pkg::CMD_SKIP_B;
			else if (sel == 0)
				b = 8'h00;
			else
				b = 8'(sel + 1);
			send_byte(ssd_pkg::LEAD_CMD);
			send_byte(b);
		end else begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Normal records at the signed byte extremes, then long jumps with both lead bytes.
		send_byte(8'h80); send_byte(8'h7F);
		send_byte(ssd_pkg::LEAD_LONG_A); send_byte(8'h00); send_byte(8'h80);
		send_byte(8'hFF); send_byte(8'h7F);
		send_byte(ssd_pkg::LEAD_LONG_B); send_byte(8'hFF); send_byte(8'h7F);
		send_byte(8'h00); send_byte(8'h80);
		// A colour stop turns the next normal stitch into a trim; a skip clears that mark.
		send_byte(ssd_pkg::LEAD_CMD); send_byte(ssd_pkg::CMD_STOP_MIN);
		send_byte(8'h01); send_byte(8'hFE);
		send_byte(ssd_pkg::LEAD_CMD); send_byte(8'hFF);
		send_byte(ssd_pkg::LEAD_CMD); send_byte(ssd_pkg::CMD_SKIP_A);
		send_byte(8'h05); send_byte(8'h05);
		send_byte(ssd_pkg::LEAD_CMD); send_byte(ssd_pkg::CMD_SKIP_B);
		send_byte(ssd_pkg::LEAD_CMD); send_byte(ssd_pkg::CMD_TRIM);
		send_byte(8'h80); send_byte(8'h7F);
		wait_for_stitches();

		sender_gaps = 1'b0;
		stall_mode  = STALL_NONE;
		while (bytes_sent < 700)
			send_record();
		wait_for_stitches();

		sender_gaps = 1'b1;
		stall_mode  = STALL_HEAVY;
		while (bytes_sent < 1300)
			send_record();
		wait_for_stitches();

		stall_mode = STALL_LIGHT;
		while (bytes_sent < RANDOM_BYTES)
			send_record();
		wait_for_stitches();
		repeat (8) @(posedge clk);

		if (sb.expected_q.size() != 0) begin
			$error("%0d stitches never arrived", sb.expected_q.size());
			sb.fail_count++;
		end
		if (sb.fail_count == 0)
			$display("stitch_stream_decoder_top_test OK");
		else
			$display("stitch_stream_decoder_top_test NOT OK");
		$finish;
	end

endmodule

// ----- stitch_stream_decoder_top.f -----
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_record.sv
hw/rtl/stitch_stream_decoder_top.sv
tb/stitch_stream_decoder_top_test.sv
